@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable sorted priority queue
// Entry layout, operation and status codes, store geometry.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int PRIO_IN_W     = 16;
  localparam int PAYLOAD_W     = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_W-1:0]     payload;
    logic                     kind;
  } entry_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    entry_t new_entry;
  } ctrl_t;

endpackage

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the shift-register priority queue
// Holds one entry, compares it with the broadcast entry and shifts with its
// neighbors on push (toward the back) or pop (toward the front).
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk,
  input  ctrl_t  ctrl,
  input  logic   occ,        // slot holds a stored entry
  input  logic   left_keep,  // left neighbor keeps its entry on push
  input  entry_t left_entry,
  input  entry_t right_entry,
  output logic   keep,
  output entry_t entry_o
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Stored entries with equal or lower priority stay in place
  assign keep    = occ && (entry_r.prio <= ctrl.new_entry.prio);
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push_en && !keep) begin
      entry_nxt = left_keep ? ctrl.new_entry : left_entry;
    end else if (ctrl.pop_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ design/stable_sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: bounded stable priority queue
// Row of CAPACITY cells kept in ascending priority order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one operation per item. tuser carries the operation
//   (push, pop, clear, no-op) and the kind tag; tdata carries priority and payload.
//   Result channel out_*: exactly one result item per input item, carrying
//   status, popped payload and kind, and the entry count after the operation.
// Timing:
//   All cells compare against the pushed priority in parallel and shift in
//   the same clock edge that loads the result into the output register.
//   One item per cycle is sustained while the receiver takes results; the
//   cell row updates together with the count register.
// Stall:
//   The output register is reloaded in the cycle it is emptied, so in_tready
//   stays high while out_tready is high; when the receiver stalls with a
//   result held, in_tready drops until it is taken.
// Reset:
//   rst_n (synchronous, active low) empties the queue and the output register.
//   Cell contents are not cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] priority_req, [47:16] payload
  input  logic [2:0]  in_tuser,   // [1:0] operation, [2] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] out_payload, [36:32] count, zero pad
  output logic [2:0]  out_tuser   // [1:0] status, [2] out_kind
);

  logic                 in_acc;
  op_t                  op;
  logic                 full;
  logic                 empty;
  ctrl_t                ctrl;
  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  keep;
  entry_t               cell_entry [CAPACITY];

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic [PAYLOAD_W-1:0] opay_r, opay_nxt;
  logic                 okind_r, okind_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser[1:0]);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);

  // Broadcast control to the cell row
  always_comb begin
    ctrl.push_en           = in_acc && (op == OP_PUSH) && !full;
    ctrl.pop_en            = in_acc && (op == OP_POP) && !empty;
    ctrl.new_entry.prio    = in_tdata[PRIORITY_BITS-1:0];
    ctrl.new_entry.payload = in_tdata[PRIO_IN_W +: PAYLOAD_W];
    ctrl.new_entry.kind    = in_tuser[2];
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_r);
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[i]),
      .left_keep   ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
      .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == CAPACITY - 1) ? ctrl.new_entry
                                        : cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
      .keep        (keep[i]),
      .entry_o     (cell_entry[i])
    );
  end

  // Count and result
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    opay_nxt   = '0;
    okind_nxt  = 1'b0;
    unique case (op)
      OP_PUSH: begin
        if (full) status_nxt = ST_FULL;
        else      count_nxt  = count_r + 1'b1;
      end
      OP_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          opay_nxt  = cell_entry[0].payload;
          okind_nxt = cell_entry[0].kind;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      opay_r   <= opay_nxt;
      okind_r  <= okind_nxt;
    end
  end

  // Count seen by the result is the one after the operation
  logic [CNT_W-1:0] res_count_r;
  always_ff @(posedge clk) begin
    if (in_acc) res_count_r <= count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(40 - PAYLOAD_W - CNT_W){1'b0}}, res_count_r, opay_r};
  assign out_tuser  = {okind_r, status_r};

endmodule

@@ design/spq_chk.sv @@
// ----------------------------------------------------------------------------
// spq_chk: port checker for the stable sorted priority queue
// Watches the result channel for consistency of status, payload and count.
// ----------------------------------------------------------------------------
module spq_chk
  import spq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Count never exceeds the store size
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36:32] <= 5'(CAPACITY)))
    else $error("count beyond capacity");

  // Pop on empty reports an empty queue with no payload
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ST_EMPTY) |->
      (out_tdata[36:32] == '0) && (out_tdata[31:0] == '0) && !out_tuser[2])
    else $error("bad empty-pop result");

  // Dropped push reports a full queue
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ST_FULL) |->
      (out_tdata[36:32] == 5'(CAPACITY)) && (out_tdata[31:0] == '0))
    else $error("bad full-push result");

  // Nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind stable_sorted_priority_queue spq_chk u_spq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ verif/spq_order_model_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_order_model_pkg: expected-order tracker for the priority queue bench
// Keeps its own sorted copy of the queue, predicts the result of every
// accepted operation and compares results against the oldest prediction.
// ----------------------------------------------------------------------------
package spq_order_model_pkg;
  import spq_pkg::*;

  // One predicted result item
  typedef struct {
    status_t               status;
    logic [PAYLOAD_W-1:0]  payload;
    logic                  kind;
    logic [CNT_W-1:0]      count;
  } queue_result_t;

  class spq_order_model;
    entry_t        stored[$];
    queue_result_t expected_results[$];
    int            mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // One line per mismatch
    task flag_mismatch(string what);
      $display("%t: mismatch: %s", $realtime, what);
      mismatch_count++;
    endtask

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted operation to the shadow queue, queue its result
    function void note_op(op_t op, logic [PRIO_IN_W-1:0] prio_req,
                          logic [PAYLOAD_W-1:0] payload, logic kind);
      entry_t        e;
      queue_result_t r;
      int            pos;
      r.status  = ST_OK;
      r.payload = '0;
      r.kind    = 1'b0;
      case (op)
        OP_PUSH: begin
          if (stored.size() >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            // high priority bits beyond the stored width are dropped
            e.prio    = prio_req[PRIORITY_BITS-1:0];
            e.payload = payload;
            e.kind    = kind;
            // insert behind all entries of equal or lower priority
            pos = 0;
            while (pos < stored.size() && stored[pos].prio <= e.prio) pos++;
            stored.insert(pos, e);
          end
        end
        OP_POP: begin
          if (stored.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            e = stored[0];
            stored.delete(0);
            r.payload = e.payload;
            r.kind    = e.kind;
          end
        end
        OP_CLEAR: begin
          stored.delete();
        end
        default: begin
        end
      endcase
      r.count = CNT_W'(stored.size());
      expected_results.insert(expected_results.size(), r);
    endfunction

    // Compare one accepted result against the oldest prediction
    task check_result(logic [1:0] status, logic [PAYLOAD_W-1:0] payload,
                      logic kind, logic [CNT_W-1:0] count);
      queue_result_t r;
      if (expected_results.size() == 0) begin
        flag_mismatch("result item with no prediction pending");
        return;
      end
      r = expected_results[0];
      expected_results.delete(0);
      if (status !== r.status)
        flag_mismatch($sformatf("status %0d, want %0d", status, r.status));
      if (payload !== r.payload)
        flag_mismatch($sformatf("payload %h, want %h", payload, r.payload));
      if (kind !== r.kind)
        flag_mismatch($sformatf("kind %b, want %b", kind, r.kind));
      if (count !== r.count)
        flag_mismatch($sformatf("count %0d, want %0d", count, r.count));
    endtask
  endclass

endpackage

@@ verif/stable_sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_tb: bench for the stable priority queue
// Directed pushes, pops and clears around the empty and full limits, then
// random operation mixes in fill and drain regimes under varying idle and
// stall patterns. Every result is checked against a shadow sorted queue.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_tb;
  import spq_pkg::*;
  import spq_order_model_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [15:0] priority_req, [47:16] payload
  logic [2:0]  in_tuser;   // [1:0] operation, [2] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] out_payload, [36:32] count, zero pad
  logic [2:0]  out_tuser;  // [1:0] status, [2] out_kind

  int src_idle_pct;
  int sink_stall_pct;

  spq_order_model queue_model;

  // Priorities of the directed fill: extremes and runs of ties
  localparam logic [15:0] FILL_PRIO [16] = '{
    16'hFFFF, 16'h0000, 16'h0005, 16'h0005, 16'h0005, 16'h0000, 16'hFFFF, 16'h0003,
    16'h8000, 16'h0005, 16'h0000, 16'h0007, 16'h7FFF, 16'h0001, 16'h0005, 16'hFFFF
  };

  stable_sorted_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Handshake monitor: note inputs first, then check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        queue_model.note_op(op_t'(in_tuser[1:0]), in_tdata[15:0], in_tdata[47:16],
                            in_tuser[2]);
      if (out_tvalid && out_tready)
        queue_model.check_result(out_tuser[1:0], out_tdata[31:0], out_tuser[2],
                                 out_tdata[36:32]);
    end
  end

  // Present one operation and hold it until accepted; entered at a falling edge
  task automatic send_op(op_t op, logic [15:0] prio, logic [31:0] payload, logic kind);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {payload, prio};
    in_tuser  <= {kind, op};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (queue_model.pending() != 0) @(negedge clk);
  endtask

  // Random operations in fill-heavy, balanced and drain-heavy regimes
  task automatic run_random(int n_ops);
    int          push_pct;
    int          pick;
    op_t         op;
    logic [15:0] prio;
    push_pct = 50;
    for (int i = 0; i < n_ops; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      pick = $urandom_range(999);
      if (pick < 15) op = OP_CLEAR;
      else if (pick < 35) op = OP_NOP;
      else if ($urandom_range(99) < push_pct) op = OP_PUSH;
      else op = OP_POP;
      // many narrow priorities so ties are common
      pick = $urandom_range(9);
      if (pick < 4) prio = 16'($urandom_range(3));
      else if (pick == 4) prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else prio = 16'($urandom);
      send_op(op, prio, $urandom, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    queue_model    = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, fill with ties and extremes, overflow, pops, clear
    send_op(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_op(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < CAPACITY; i++) begin
      send_op(OP_PUSH, FILL_PRIO[i],
              (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : 32'hA500_0000 | i,
              1'(i));
    end
    send_op(OP_PUSH, 16'h0000, 32'h5A5A_5A5A, 1'b1);
    send_op(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_op(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    send_op(OP_NOP, 16'h1234, 32'h1234_5678, 1'b1);
    send_op(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_op(OP_POP, 16'h0000, 32'h0000_0000, 1'b0);
    drain_results();

    // Random phases: no idling, sender idle, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      run_random(385);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (queue_model.mismatch_count == 0) begin
      $display("stable_sorted_priority_queue_tb: done, clean");
    end else begin
      $display("stable_sorted_priority_queue_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("stable_sorted_priority_queue_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
design/spq_pkg.sv
design/spq_cell.sv
design/stable_sorted_priority_queue.sv
design/spq_chk.sv
verif/spq_order_model_pkg.sv
verif/stable_sorted_priority_queue_tb.sv
